[src/bpa_pkg.sv]
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int PAGE_W = 16;
    localparam int CNT_W  = 17;
    localparam int CUR_W  = 18;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_BAD     = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_RUN  = 2'd1;
    localparam logic [1:0] STS_ZERO    = 2'd2;
    localparam logic [1:0] STS_SKIPPED = 2'd3;

    typedef enum logic [1:0] {
        OP_COUNT,
        OP_SET,
        OP_CLEAR
    } bpa_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_BIT,
        ST_MARK,
        ST_RNG_RD,
        ST_RNG_EV,
        ST_RESULT
    } bpa_state_t;

    typedef struct packed {
        logic init_wr;
        logic recount_start;
        logic req_load;
        logic scan_start;
        logic rd;
        logic scan_word;
        logic bit_step;
        logic no_run;
        logic mark;
        logic rng_eval;
        logic out_load;
    } bpa_cmd_t;

    typedef struct packed {
        logic init_last;
        logic recount_pending;
        logic req_zero;
        logic req_alloc;
        logic scan_end;
        logic sw_found;
        logic sw_mixed;
        logic bit_found;
        logic bit_wrap;
        logic rng_done;
        logic op_count;
        logic out_full;
    } bpa_stat_t;

endpackage

[src/bpa_if.sv]
`timescale 1ns / 1ps

interface bpa_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [bpa_pkg::PAGE_W-1:0] range_base;
    logic [bpa_pkg::CNT_W-1:0]  num_pages;

    modport source (output valid, cmd, range_base, num_pages, input ready);
    modport sink   (input valid, cmd, range_base, num_pages, output ready);
endinterface

interface bpa_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [bpa_pkg::PAGE_W-1:0] first_page;
    logic [bpa_pkg::CNT_W-1:0]  skipped_pages;
    logic [bpa_pkg::CNT_W-1:0]  free_total;
    logic [bpa_pkg::CNT_W-1:0]  used_total;

    modport source (output valid, status, first_page, skipped_pages, free_total,
                    used_total, input ready);
    modport sink   (input valid, status, first_page, skipped_pages, free_total,
                    used_total, output ready);
endinterface

interface bpa_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [bpa_pkg::CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/bpa_ctrl.sv]
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  bpa_pkg::bpa_stat_t stat,
    input  logic               req_valid,
    output logic               req_ready,
    output bpa_pkg::bpa_cmd_t  cmd
);
    import bpa_pkg::*;

    bpa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (stat.recount_pending)
                    state_next = ST_RNG_RD;
                else if (req_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (stat.req_zero)
                    state_next = ST_RESULT;
                else if (stat.req_alloc)
                    state_next = ST_SCAN_RD;
                else
                    state_next = ST_RNG_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = stat.scan_end ? ST_RESULT : ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (stat.sw_found)
                    state_next = ST_MARK;
                else if (stat.sw_mixed)
                    state_next = ST_BIT;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_BIT:
            begin
                if (stat.scan_end)
                    state_next = ST_RESULT;
                else if (stat.bit_found)
                    state_next = ST_MARK;
                else if (stat.bit_wrap)
                    state_next = ST_SCAN_RD;
            end
            ST_MARK:
            begin
                state_next = ST_RNG_RD;
            end
            ST_RNG_RD:
            begin
                if (stat.rng_done)
                    state_next = stat.op_count ? ST_IDLE : ST_RESULT;
                else
                    state_next = ST_RNG_EV;
            end
            ST_RNG_EV:
            begin
                state_next = ST_RNG_RD;
            end
            ST_RESULT:
            begin
                if (!stat.out_full)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready         = !stat.recount_pending;
                cmd.recount_start = stat.recount_pending;
                cmd.req_load      = !stat.recount_pending && req_valid;
            end
            ST_DECODE:
            begin
                cmd.scan_start = !stat.req_zero && stat.req_alloc;
            end
            ST_SCAN_RD:
            begin
                cmd.no_run = stat.scan_end;
                cmd.rd     = !stat.scan_end;
            end
            ST_SCAN_EV:
            begin
                cmd.scan_word = 1'b1;
            end
            ST_BIT:
            begin
                cmd.no_run   = stat.scan_end;
                cmd.bit_step = !stat.scan_end;
            end
            ST_MARK:
            begin
                cmd.mark = 1'b1;
            end
            ST_RNG_RD:
            begin
                cmd.rd = !stat.rng_done;
            end
            ST_RNG_EV:
            begin
                cmd.rng_eval = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.out_load = !stat.out_full;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/bpa_dp.sv]
`timescale 1ns / 1ps

module bpa_dp #(
    parameter int MAX_PAGES     = 65536,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bpa_pkg::bpa_cmd_t cmd,
    output bpa_pkg::bpa_stat_t stat,
    bpa_cfg_if.sink           cfg,
    bpa_req_if.sink           req,
    bpa_rsp_if.source         rsp
);
    import bpa_pkg::*;

    localparam int W         = MAP_WORD_BITS;
    localparam int BW        = $clog2(W);
    localparam int MAP_WORDS = (MAX_PAGES + W - 1) / W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PCW       = $clog2(W + 1);
    localparam int T_MAX     = (MAX_PAGES > 65536) ? 65536 : MAX_PAGES;

    function automatic logic [PCW-1:0] pop(input logic [W-1:0] v);
        logic [PCW-1:0] s;
        s = '0;
        for (int i = 0; i < W; i++)
            s = s + PCW'(v[i]);
        return s;
    endfunction

    logic [W-1:0] map_mem [MAP_WORDS];
    logic [W-1:0] q_reg;

    // control state
    logic [CNT_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    init_addr_reg, init_addr_next;
    logic             out_valid_reg, out_valid_next;

    // payload / working registers
    logic [CUR_W-1:0] cur_reg, cur_next;
    logic [CUR_W-1:0] hi_reg, hi_next;
    logic [CUR_W-1:0] run_reg, run_next;
    logic [CUR_W-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0] skip_reg, skip_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       cmd_reg, cmd_next;
    bpa_op_t          op_reg, op_next;
    logic             fail_reg, fail_next;
    logic [1:0]       o_status_reg, o_status_next;
    logic [PAGE_W-1:0] o_first_reg, o_first_next;
    logic [CNT_W-1:0] o_skip_reg, o_skip_next;
    logic [CNT_W-1:0] o_free_reg, o_free_next;
    logic [CNT_W-1:0] o_used_reg, o_used_next;

    logic [CUR_W-1:0] t_ext, cnt_ext, base, next_base, run_plus, run_inc;
    logic [W-1:0]     in_t, in_rng, fm, chg, skp, wd_eval;
    logic             full, empty, bfree;
    logic [AW-1:0]    word_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [W-1:0]     mem_wd;
    logic [CUR_W-1:0] lo_in, hi_raw, hi_cl, inr;
    logic             is_range;

    assign t_ext     = {1'b0, t_reg};
    assign cnt_ext   = {1'b0, cnt_reg};
    assign base      = {cur_reg[CUR_W-1:BW], {BW{1'b0}}};
    assign next_base = base + CUR_W'(W);
    assign word_addr = AW'(cur_reg >> BW);
    assign run_plus  = run_reg + CUR_W'(W);
    assign run_inc   = run_reg + CUR_W'(1);
    assign is_range  = (cmd_reg == CMD_FREE) || (cmd_reg == CMD_RESERVE);

    always_comb
    begin
        logic [CUR_W-1:0] pg;
        pg = '0;
        for (int b = 0; b < W; b++)
        begin
            pg        = base + CUR_W'(b);
            in_t[b]   = pg < t_ext;
            in_rng[b] = (pg >= cur_reg) && (pg < hi_reg);
        end
    end

    assign fm    = ~q_reg & in_t;
    assign full  = &fm;
    assign empty = ~|fm;
    assign bfree = ~q_reg[cur_reg[BW-1:0]];

    always_comb
    begin
        case (op_reg)
            OP_SET:
            begin
                chg     = in_rng & ~q_reg;
                skp     = in_rng & q_reg;
                wd_eval = q_reg | in_rng;
            end
            OP_CLEAR:
            begin
                chg     = in_rng & q_reg;
                skp     = in_rng & ~q_reg;
                wd_eval = q_reg & ~in_rng;
            end
            default:
            begin
                chg     = in_rng & ~q_reg;
                skp     = '0;
                wd_eval = q_reg;
            end
        endcase
    end

    // range setup straight from the request fields
    assign lo_in  = {2'b00, req.range_base};
    assign hi_raw = lo_in + {1'b0, req.num_pages};
    assign hi_cl  = (hi_raw > t_ext) ? t_ext : hi_raw;
    assign inr    = (hi_cl > lo_in) ? (hi_cl - lo_in) : '0;

    assign stat.init_last       = (init_addr_reg == AW'(MAP_WORDS - 1));
    assign stat.recount_pending = pend_reg;
    assign stat.req_zero        = (cnt_reg == '0) || (cmd_reg == CMD_BAD);
    assign stat.req_alloc       = (cmd_reg == CMD_ALLOC);
    assign stat.scan_end        = (cur_reg >= t_ext);
    assign stat.sw_found        = full && (run_plus >= cnt_ext);
    assign stat.sw_mixed        = !full && !empty;
    assign stat.bit_found       = bfree && (run_inc == cnt_ext);
    assign stat.bit_wrap        = (cur_reg[BW-1:0] == {BW{1'b1}});
    assign stat.rng_done        = (cur_reg >= hi_reg);
    assign stat.op_count        = (op_reg == OP_COUNT);
    assign stat.out_full        = out_valid_reg && !rsp.ready;

    assign cfg.ready = 1'b1;
    assign req.ready = 1'b0 | cmd.req_load;

    assign mem_we = cmd.init_wr || (cmd.rng_eval && (op_reg != OP_COUNT));
    assign mem_wa = cmd.init_wr ? init_addr_reg : word_addr;
    assign mem_wd = cmd.init_wr ? {W{1'b1}} : wd_eval;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_wa] <= mem_wd;
        if (cmd.rd)
            q_reg <= map_mem[word_addr];
    end

    always_comb
    begin
        t_next         = t_reg;
        free_next      = free_reg;
        pend_next      = pend_reg;
        init_addr_next = init_addr_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        hi_next        = hi_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        skip_next      = skip_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        op_next        = op_reg;
        fail_next      = fail_reg;
        o_status_next  = o_status_reg;
        o_first_next   = o_first_reg;
        o_skip_next    = o_skip_reg;
        o_free_next    = o_free_reg;
        o_used_next    = o_used_reg;

        if (cmd.init_wr)
            init_addr_next = init_addr_reg + AW'(1);

        if (cmd.recount_start)
        begin
            pend_next = 1'b0;
            free_next = '0;
            cur_next  = '0;
            hi_next   = t_ext;
            op_next   = OP_COUNT;
        end

        // a write landing on the recount start keeps another recount pending
        if (cfg.valid)
        begin
            t_next    = (cfg.data > CNT_W'(T_MAX)) ? CNT_W'(T_MAX) : cfg.data;
            pend_next = 1'b1;
        end

        if (cmd.req_load)
        begin
            cmd_next  = req.cmd;
            cnt_next  = req.num_pages;
            fail_next = 1'b0;
            cur_next  = lo_in;
            hi_next   = hi_cl;
            op_next   = (req.cmd == CMD_RESERVE) ? OP_SET : OP_CLEAR;
            skip_next = req.num_pages - inr[CNT_W-1:0];
        end

        if (cmd.scan_start)
        begin
            cur_next = '0;
            run_next = '0;
        end

        if (cmd.scan_word)
        begin
            if (full)
            begin
                if (run_reg == '0)
                    run_start_next = base;
                run_next = run_plus;
                if (!stat.sw_found)
                    cur_next = next_base;
            end
            else if (empty)
            begin
                run_next = '0;
                cur_next = next_base;
            end
        end

        if (cmd.bit_step)
        begin
            if (bfree)
            begin
                if (run_reg == '0)
                    run_start_next = cur_reg;
                run_next = run_inc;
            end
            else
            begin
                run_next = '0;
            end
            cur_next = cur_reg + CUR_W'(1);
        end

        if (cmd.no_run)
            fail_next = 1'b1;

        if (cmd.mark)
        begin
            cur_next = run_start_reg;
            hi_next  = run_start_reg + cnt_ext;
            op_next  = OP_SET;
        end

        if (cmd.rng_eval)
        begin
            if (op_reg == OP_SET)
                free_next = free_reg - CNT_W'(pop(chg));
            else
                free_next = free_reg + CNT_W'(pop(chg));
            skip_next = skip_reg + CNT_W'(pop(skp));
            cur_next  = next_base;
        end

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            if (stat.req_zero)
                o_status_next = STS_ZERO;
            else if (stat.req_alloc)
                o_status_next = fail_reg ? STS_NO_RUN : STS_OK;
            else
                o_status_next = (skip_reg != '0) ? STS_SKIPPED : STS_OK;
            o_first_next = (!stat.req_zero && stat.req_alloc && !fail_reg)
                         ? run_start_reg[PAGE_W-1:0] : '0;
            o_skip_next  = (!stat.req_zero && is_range) ? skip_reg : '0;
            o_free_next  = free_reg;
            o_used_next  = (t_reg >= free_reg) ? (t_reg - free_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg         <= CNT_W'(T_MAX);
            free_reg      <= '0;
            pend_reg      <= 1'b0;
            init_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            t_reg         <= t_next;
            free_reg      <= free_next;
            pend_reg      <= pend_next;
            init_addr_reg <= init_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        hi_reg        <= hi_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        skip_reg      <= skip_next;
        cnt_reg       <= cnt_next;
        cmd_reg       <= cmd_next;
        op_reg        <= op_next;
        fail_reg      <= fail_next;
        o_status_reg  <= o_status_next;
        o_first_reg   <= o_first_next;
        o_skip_reg    <= o_skip_next;
        o_free_reg    <= o_free_next;
        o_used_reg    <= o_used_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.first_page    = o_first_reg;
    assign rsp.skipped_pages = o_skip_reg;
    assign rsp.free_total    = o_free_reg;
    assign rsp.used_total    = o_used_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !rsp.ready))
        else $error("result register overwritten while held");

    a_set_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rng_eval && op_reg == OP_SET && !cfg.valid) |=> free_reg <= $past(free_reg))
        else $error("marking pages used raised the free count");

    a_clear_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rng_eval && op_reg == OP_CLEAR) |=> free_reg >= $past(free_reg))
        else $error("freeing pages lowered the free count");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |=> hi_reg <= {1'b0, t_reg})
        else $error("allocated run reaches past the page total");

endmodule

[src/bitmap_page_allocator.sv]
`timescale 1ns / 1ps

// Bitmap first-fit page frame allocator, one bit per page (1 = used).
// cfg: write the page total, clamped to at most 65536; always ready. A write
//   triggers a recount of free pages below it, before the next request.
// req: cmd / range_base / num_pages. rsp: status, first_page, skipped_pages,
//   free_total, used_total; one response per request.
// One request is in flight at a time; each map word goes through the memory
//   port as a registered read, then an evaluate/write back. Allocate scans
//   word by word, steps page by page inside words that are partly free, then
//   marks the run word by word. Free/reserve visit each word touched.
//   Zero-count requests go from decode straight to the result.
// Reset: free count zero; an init pass then writes every map word all ones
//   (every page used), MAP_WORDS = ceil(MAX_PAGES/MAP_WORD_BITS) words, one
//   per cycle, during which req is not ready (cfg writes are still taken).
// A finished response sits in an output register; a new request is taken
//   while it waits, but the next response holds until rsp is drained.
module bitmap_page_allocator #(
    parameter int MAX_PAGES     = 65536,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    bpa_cfg_if.sink   cfg,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp
);
    import bpa_pkg::*;

    bpa_cmd_t  cmd;
    bpa_stat_t stat;
    logic      ctl_ready;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .req_valid (req.valid),
        .req_ready (ctl_ready),
        .cmd       (cmd)
    );

    bpa_dp #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> ctl_ready)
        else $error("request taken outside idle");

endmodule

[dv/bitmap_page_allocator_tb.sv]
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam int NUM_PAGES   = 65536;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]       status;
        logic [PAGE_W-1:0] first_page;
        logic [CNT_W-1:0]  skipped_pages;
        logic [CNT_W-1:0]  free_total;
        logic [CNT_W-1:0]  used_total;
    } alloc_rsp_t;

    typedef struct {
        bit                is_cfg;
        logic [1:0]        cmd;
        logic [PAGE_W-1:0] range_base;
        logic [CNT_W-1:0]  num_pages;
        bit                typed;
        alloc_rsp_t        rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bpa_cfg_if cfg_ch ();
    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    bitmap_page_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow allocator state
    bit          page_used [0:NUM_PAGES-1];
    int unsigned free_left;
    int unsigned managed_pages;

    alloc_rsp_t  rsp_q [$];
    dir_row_t    dir_tab [$];
    int          fail_cnt;
    int          rsp_cnt;
    int          alloc_hits;
    int          alloc_misses;
    int          skip_rsps;
    int          cfg_writes;
    int unsigned cycle_cnt;
    int          stall_pct;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;
    int          burst_left;

    always #4 clk = ~clk;

    function automatic int unsigned usable_pages();
        return (managed_pages > NUM_PAGES) ? NUM_PAGES : managed_pages;
    endfunction

    function automatic void set_total(logic [CNT_W-1:0] v);
        int unsigned n;
        n = 0;
        managed_pages = 32'(v);
        for (int unsigned p = 0; p < usable_pages(); p++)
            if (!page_used[p])
                n++;
        free_left = n;
    endfunction

    function automatic alloc_rsp_t apply_request(logic [1:0] c, logic [PAGE_W-1:0] s,
                                                 logic [CNT_W-1:0] n);
        alloc_rsp_t  r;
        int unsigned t;
        int unsigned run;
        int unsigned run_start;
        int unsigned skip;
        int unsigned p;
        bit          found;
        bit          tgt;
        r = '0;
        t = usable_pages();
        run = 0;
        run_start = 0;
        skip = 0;
        found = 0;
        if (n == 0 || c == CMD_BAD) begin
            r.status = STS_ZERO;
        end
        else if (c == CMD_ALLOC) begin
            for (int unsigned i = 0; i < t && !found; i++) begin
                if (!page_used[i])
                begin
                    if (run == 0)
                        run_start = i;
                    run++;
                    if (run == n)
                        found = 1;
                end
                else
                begin
                    run = 0;
                end
            end
            if (found)
            begin
                for (int unsigned i = 0; i < n; i++)
                    page_used[run_start + i] = 1;
                free_left -= n;
                r.first_page = PAGE_W'(run_start);
                alloc_hits++;
            end
            else
            begin
                r.status = STS_NO_RUN;
                alloc_misses++;
            end
        end
        else
        begin
            tgt = (c == CMD_RESERVE);
            for (int unsigned i = 0; i < n; i++) begin
                p = s + i;
                if (p >= t || page_used[p] == tgt)
                begin
                    skip++;
                end
                else
                begin
                    page_used[p] = tgt;
                    if (tgt)
                        free_left--;
                    else
                        free_left++;
                end
            end
            if (skip != 0)
            begin
                r.status = STS_SKIPPED;
                skip_rsps++;
            end
        end
        r.skipped_pages = CNT_W'(skip);
        r.free_total = CNT_W'(free_left);
        r.used_total = CNT_W'((t >= free_left) ? t - free_left : 0);
        return r;
    endfunction

    // request is launched at the current edge; returns at the accepting edge
    task automatic send_request(logic [1:0] c, logic [PAGE_W-1:0] s, logic [CNT_W-1:0] n,
                                bit typed, alloc_rsp_t typed_rsp);
        alloc_rsp_t r;
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= c;
        req_ch.range_base <= s;
        req_ch.num_pages  <= n;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = apply_request(c, s, n);
        rsp_q.push_back(typed ? typed_rsp : r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_total(logic [CNT_W-1:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        set_total(v);
        cfg_writes++;
    endtask

    function automatic void add_row(bit is_cfg, logic [1:0] c, logic [PAGE_W-1:0] s,
                                    logic [CNT_W-1:0] n, bit typed, logic [1:0] st,
                                    logic [PAGE_W-1:0] fp, logic [CNT_W-1:0] sk,
                                    logic [CNT_W-1:0] fr, logic [CNT_W-1:0] us);
        dir_row_t d;
        d.is_cfg = is_cfg;
        d.cmd = c;
        d.range_base = s;
        d.num_pages = n;
        d.typed = typed;
        d.rsp = '{st, fp, sk, fr, us};
        dir_tab.push_back(d);
    endfunction

    // response checker
    always @(posedge clk)
    begin
        alloc_rsp_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_cnt++;
            if (rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d", $time, rsp_ch.status);
                fail_cnt++;
            end
            else
            begin
                e = rsp_q.pop_front();
                if (rsp_ch.status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, rsp_ch.status);
                    fail_cnt++;
                end
                if (rsp_ch.first_page !== e.first_page)
                begin
                    $display("%0t: first_page exp %0d got %0d", $time, e.first_page,
                             rsp_ch.first_page);
                    fail_cnt++;
                end
                if (rsp_ch.skipped_pages !== e.skipped_pages)
                begin
                    $display("%0t: skipped_pages exp %0d got %0d", $time, e.skipped_pages,
                             rsp_ch.skipped_pages);
                    fail_cnt++;
                end
                if (rsp_ch.free_total !== e.free_total)
                begin
                    $display("%0t: free_total exp %0d got %0d", $time, e.free_total,
                             rsp_ch.free_total);
                    fail_cnt++;
                end
                if (rsp_ch.used_total !== e.used_total)
                begin
                    $display("%0t: used_total exp %0d got %0d", $time, e.used_total,
                             rsp_ch.used_total);
                    fail_cnt++;
                end
            end
        end
    end

    // response backpressure: random stalls plus a single long hold
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_reqs)
        begin
            rsp_ch.ready <= 1'b0;
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned totals [9];
        int          counts [9];
        int unsigned t;
        int unsigned lim;
        logic [1:0]        c;
        logic [PAGE_W-1:0] s;
        logic [CNT_W-1:0]  n;
        int unsigned       k;
        int                gap;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.range_base = '0;
        req_ch.num_pages = '0;
        rsp_ch.ready = 1'b0;
        stall_pct = 0;
        hold_reqs = 0;
        hold_seen = 0;
        hold_left = 0;
        fail_cnt = 0;
        cycle_cnt = 0;
        burst_left = 0;
        for (int i = 0; i < NUM_PAGES; i++)
            page_used[i] = 1;
        free_left = 0;
        managed_pages = NUM_PAGES;

        add_row(0, CMD_ALLOC,   0,     1,     1, STS_NO_RUN,  0, 0,     0,  65536);
        add_row(0, CMD_FREE,    0,     0,     1, STS_ZERO,    0, 0,     0,  65536);
        add_row(0, CMD_BAD,     7,     5,     1, STS_ZERO,    0, 0,     0,  65536);
        add_row(0, CMD_FREE,    0,     64,    1, STS_OK,      0, 0,     64, 65472);
        add_row(0, CMD_ALLOC,   0,     64,    1, STS_OK,      0, 0,     0,  65536);
        add_row(0, CMD_FREE,    65535, 65536, 1, STS_SKIPPED, 0, 65535, 1,  65535);
        add_row(0, CMD_RESERVE, 65535, 2,     1, STS_SKIPPED, 0, 1,     0,  65536);
        add_row(0, CMD_ALLOC,   0,     65536, 1, STS_NO_RUN,  0, 0,     0,  65536);
        add_row(0, CMD_FREE,    100,   10,    0, 0, 0, 0, 0, 0);
        add_row(0, CMD_RESERVE, 100,   20,    0, 0, 0, 0, 0, 0);
        add_row(0, CMD_FREE,    0,     300,   0, 0, 0, 0, 0, 0);
        add_row(0, CMD_ALLOC,   0,     5,     0, 0, 0, 0, 0, 0);
        add_row(0, CMD_ALLOC,   0,     200,   0, 0, 0, 0, 0, 0);
        add_row(0, CMD_RESERVE, 0,     65535, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, CMD_ALLOC,   0,     1,     1, STS_NO_RUN,  0, 0,     0,  0);
        add_row(0, CMD_FREE,    0,     1,     1, STS_SKIPPED, 0, 1,     0,  0);
        add_row(1, 0, 0, 131071, 0, 0, 0, 0, 0, 0);
        add_row(0, CMD_FREE,    32768, 65536, 0, 0, 0, 0, 0, 0);
        add_row(0, CMD_ALLOC,   0,     32768, 0, 0, 0, 0, 0, 0);
        add_row(0, CMD_FREE,    65520, 16,    0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 10, 0, 0, 0, 0, 0, 0);
        add_row(0, CMD_ALLOC,   0,     11,    0, 0, 0, 0, 0, 0);
        add_row(0, CMD_FREE,    5,     5,     0, 0, 0, 0, 0, 0);
        add_row(0, CMD_ALLOC,   0,     5,     0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_total(dir_tab[i].num_pages);
            else
                send_request(dir_tab[i].cmd, dir_tab[i].range_base, dir_tab[i].num_pages,
                             dir_tab[i].typed, dir_tab[i].rsp);
        end

        // random phases: mostly small totals, a few at full size and saturated
        totals = '{300, 0, 1, 1024, 131071, 700, 65536, 64, 2000};
        counts = '{90, 20, 25, 90, 20, 90, 20, 70, 130};
        foreach (totals[ph])
        begin
            write_total(CNT_W'(totals[ph]));
            stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 70;
            t = usable_pages();
            lim = (t == 0) ? 1 : t;
            for (int i = 0; i < counts[ph]; i++)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap != 0)
                    begin
                        req_ch.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (ph == 3 && i == 30)
                    hold_reqs++;
                if (ph == 5 && i == 40)
                    drain();
                k = $urandom_range(0, 99);
                c = (k < 40) ? CMD_ALLOC : (k < 72) ? CMD_FREE :
                    (k < 94) ? CMD_RESERVE : CMD_BAD;
                if ($urandom_range(0, 9) == 0)
                    s = PAGE_W'($urandom_range(0, 65535));
                else
                    s = PAGE_W'($urandom_range(0, lim - 1));
                k = $urandom_range(0, 99);
                if (k < 4)
                    n = '0;
                else if (k < 9)
                    n = CNT_W'($urandom_range(1, 65536));
                else if (c == CMD_ALLOC)
                    n = CNT_W'($urandom_range(1, lim / 16 + 1));
                else
                    n = CNT_W'($urandom_range(1, lim / 4 + 1));
                send_request(c, s, n, 0, '0);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("responses %0d, allocations %0d ok / %0d without run, %0d partial ranges",
                 rsp_cnt, alloc_hits, alloc_misses, skip_rsps);
        $display("page totals written %0d times, incl. zero, one and saturated", cfg_writes);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
